@@ rtl/core/tmplan_pkg.sv @@
`default_nettype none

package tmplan_pkg;

    // Register indexes of the configuration port.
    typedef enum logic [1:0] {
        CFG_START_RATE = 2'd0,
        CFG_TOP_RATE   = 2'd1,
        CFG_ACCEL_RATE = 2'd2,
        CFG_DECEL_RATE = 2'd3
    } t_cfg_idx;

    localparam int unsigned RateW      = 16;
    localparam int unsigned StepW      = 32;
    localparam int unsigned CfgIdxW    = 2;

    // Ramp length arithmetic: t = 4096 * d / rate, ramp = ((t >> 4) * s + 62500) / 125000.
    localparam int unsigned TScaleSh   = 12;
    localparam int unsigned TDropSh    = 4;
    localparam logic [31:0] RoundAdd   = 32'd62500;
    localparam int unsigned SeqSteps   = 32;
    localparam int unsigned SeqCntW    = $clog2(SeqSteps);

    // Division by 125000 = 8 * 15625: drop the three low bits, then multiply by the
    // rounded-up reciprocal of 15625 scaled by 2^43. This is exact for every 29-bit value.
    localparam int unsigned RampPreSh  = 3;
    localparam logic [29:0] RecipMul   = 30'd562949954;
    localparam int unsigned RecipSh    = 43;

    // Item pipeline: sign, compare, multiply, then the divider stages.
    localparam int unsigned DivBits    = 16;
    localparam int unsigned BitsPerStg = 2;
    localparam int unsigned DivStg     = DivBits / BitsPerStg;
    localparam int unsigned NumStg     = 3 + DivStg;

    // One-hot states of the ramp length sequencer.
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_LOAD = 6'b000010,
        ST_DIVT = 6'b000100,
        ST_MUL  = 6'b001000,
        ST_ADD  = 6'b010000,
        ST_DIVR = 6'b100000
    } t_rstate;

    typedef struct packed {
        logic                 neg;
        logic                 zero;
        logic                 err;
        logic                 long_mv;
        logic [StepW-1:0]     n;
        logic [StepW-1:0]     run;
        logic [DivBits-1:0]   rem;
        logic [DivBits-1:0]   quo;
    } t_item;

    // One restoring division step: shift in the next dividend bit from the top of quo.
    function automatic t_item div_step(t_item a, logic [DivBits-1:0] den);
        t_item            r;
        logic [DivBits:0] tmp;
        logic [DivBits:0] sub;
        logic             ge;
        r   = a;
        tmp = {a.rem, a.quo[DivBits-1]};
        sub = tmp - {1'b0, den};
        ge  = (tmp >= {1'b0, den});
        r.rem = ge ? sub[DivBits-1:0] : tmp[DivBits-1:0];
        r.quo = {a.quo[DivBits-2:0], ge};
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/trapezoid_move_planner.sv @@
`default_nettype none

// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+----------------------------------------
// move in   | input     | i_in_valid / o_in_stall    | i_move_steps
// plan out  | output    | o_out_valid / i_out_stall  | o_direction, o_accel_steps, o_run_steps,
//           |           |                            | o_decel_steps, o_phase_mask, o_no_motion,
//           |           |                            | o_divide_error
// config    | input     | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// A move item can enter every cycle while the input is not stalled and passes through a
// pipeline of a sign stage, a compare stage, a 16x16 multiply stage, eight divider stages
// of two quotient bits each, and the output register.
// After any configuration write, a shared serial divider works out 4096 * d / rate one bit
// per cycle and a reciprocal multiply replaces the division by 125000, first for the
// acceleration ramp and then for the deceleration ramp; the input is stalled during that time.
// Reset is synchronous and active low; it loads the register defaults, whose ramps are zero,
// so no recomputation follows reset.
// A stall on a valid output freezes the whole pipeline, which is one register per stage.

module trapezoid_move_planner (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire [tmplan_pkg::CfgIdxW-1:0]       i_cfg_idx,
    input  wire [tmplan_pkg::RateW-1:0]         i_cfg_data,
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire signed [tmplan_pkg::StepW-1:0]  i_move_steps,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output logic                                o_direction,
    output logic [15:0]                         o_accel_steps,
    output logic [31:0]                         o_run_steps,
    output logic [15:0]                         o_decel_steps,
    output logic [2:0]                          o_phase_mask,
    output logic                                o_no_motion,
    output logic                                o_divide_error
);

    localparam int unsigned RW = tmplan_pkg::RateW;
    localparam int unsigned SW = tmplan_pkg::StepW;
    localparam int unsigned NS = tmplan_pkg::NumStg;

    // Configuration registers.
    logic [RW-1:0] r_start_rate;
    logic [RW-1:0] r_top_rate;
    logic [RW-1:0] r_accel_rate;
    logic [RW-1:0] r_decel_rate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_rate <= '0;
            r_top_rate   <= '0;
            r_accel_rate <= RW'(1);
            r_decel_rate <= RW'(1);
        end else if (i_cfg_we) begin
            case (tmplan_pkg::t_cfg_idx'(i_cfg_idx))
                tmplan_pkg::CFG_START_RATE: r_start_rate <= i_cfg_data;
                tmplan_pkg::CFG_TOP_RATE:   r_top_rate   <= i_cfg_data;
                tmplan_pkg::CFG_ACCEL_RATE: r_accel_rate <= i_cfg_data;
                tmplan_pkg::CFG_DECEL_RATE: r_decel_rate <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Ramp length sequencer. Both ramps depend on configuration only, so they are worked
    // out once per configuration change with one shared restoring divider for the rate
    // division and a reciprocal multiply for the division by 125000.
    tmplan_pkg::t_rstate            r_state;
    logic                           r_sel;
    logic [tmplan_pkg::SeqCntW-1:0] r_cnt;
    logic [RW-1:0]                  r_na;
    logic [RW-1:0]                  r_nd;
    logic [31:0]                    r_quo;
    logic [16:0]                    r_rem;
    logic [16:0]                    r_div;
    logic [31:0]                    r_prod;

    logic [RW-1:0] w_diff;
    logic [RW-1:0] w_sum;
    logic [RW-1:0] w_rate;
    logic [17:0]   w_dtmp;
    logic [17:0]   w_dsub;
    logic          w_dge;
    logic [31:0]   w_qnext;
    logic [39:0]   w_mul;
    logic [58:0]   w_recip;
    logic [RW-1:0] w_ramp;
    logic          w_last;

    assign w_diff  = r_top_rate - r_start_rate;
    assign w_sum   = r_top_rate + r_start_rate;
    assign w_rate  = r_sel ? r_decel_rate : r_accel_rate;
    assign w_dtmp  = {r_rem, r_quo[31]};
    assign w_dsub  = w_dtmp - {1'b0, r_div};
    assign w_dge   = (w_dtmp >= {1'b0, r_div});
    assign w_qnext = {r_quo[30:0], w_dge};
    assign w_mul   = r_quo[27:tmplan_pkg::TDropSh] * w_sum;
    // The rounded product is below 2^32, so the quotient by 125000 fits in 16 bits.
    assign w_recip = r_quo[31:tmplan_pkg::RampPreSh] * tmplan_pkg::RecipMul;
    assign w_ramp  = w_recip[tmplan_pkg::RecipSh +: RW];
    assign w_last  = (r_cnt == tmplan_pkg::SeqCntW'(tmplan_pkg::SeqSteps - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tmplan_pkg::ST_IDLE;
            r_sel   <= 1'b0;
            r_cnt   <= '0;
            r_na    <= '0;
            r_nd    <= '0;
        end else if (i_cfg_we) begin
            r_state <= tmplan_pkg::ST_LOAD;
            r_sel   <= 1'b0;
        end else begin
            case (r_state)
                tmplan_pkg::ST_LOAD: begin
                    r_cnt   <= '0;
                    r_state <= tmplan_pkg::ST_DIVT;
                end
                tmplan_pkg::ST_DIVT: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (w_last) begin
                        r_state <= tmplan_pkg::ST_MUL;
                    end
                end
                tmplan_pkg::ST_MUL: begin
                    r_state <= tmplan_pkg::ST_ADD;
                end
                tmplan_pkg::ST_ADD: begin
                    r_state <= tmplan_pkg::ST_DIVR;
                end
                tmplan_pkg::ST_DIVR: begin
                    if (r_sel) begin
                        r_nd    <= w_ramp;
                        r_state <= tmplan_pkg::ST_IDLE;
                    end else begin
                        r_na    <= w_ramp;
                        r_sel   <= 1'b1;
                        r_state <= tmplan_pkg::ST_LOAD;
                    end
                end
                default: r_state <= tmplan_pkg::ST_IDLE;
            endcase
        end
    end

    // Divider datapath: r_quo holds the dividend bits still to come and the quotient so far.
    always_ff @(posedge i_clk) begin
        case (r_state)
            tmplan_pkg::ST_LOAD: begin
                r_quo <= {4'b0, w_diff, {tmplan_pkg::TScaleSh{1'b0}}};
                r_rem <= '0;
                r_div <= {1'b0, w_rate};
            end
            tmplan_pkg::ST_DIVT: begin
                r_quo <= w_qnext;
                r_rem <= w_dge ? w_dsub[16:0] : w_dtmp[16:0];
            end
            tmplan_pkg::ST_MUL: begin
                r_prod <= w_mul[31:0];
            end
            tmplan_pkg::ST_ADD: begin
                r_quo <= r_prod + tmplan_pkg::RoundAdd;
            end
            default: ;
        endcase
    end

    // Item pipeline. The whole pipeline advances when the output register can take data.
    logic                  w_en;
    logic                  w_accept;
    logic [RW-1:0]         w_total;
    logic [31:0]           w_prod;
    logic [SW-1:0]         w_raw;
    tmplan_pkg::t_item     r_stg [NS];
    tmplan_pkg::t_item     n_stg [NS];
    logic [NS-1:0]         r_vld;
    tmplan_pkg::t_item     v_div;

    assign w_en       = !(o_out_valid && i_out_stall);
    assign o_in_stall = !w_en || (r_state != tmplan_pkg::ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_total    = r_na + r_nd;
    assign w_raw      = $unsigned(i_move_steps);
    assign w_prod     = r_na * r_stg[1].n[15:0];

    always_comb begin
        v_div = '0;
        // Sign stage: magnitude of the move, with the most negative value kept as 2^31.
        n_stg[0]       = '0;
        n_stg[0].neg   = w_raw[SW-1];
        n_stg[0].n     = w_raw[SW-1] ? (SW'(0) - w_raw) : w_raw;
        n_stg[0].zero  = (w_raw == '0);
        n_stg[0].err   = (r_accel_rate == '0) || (r_decel_rate == '0);
        // Compare stage: full ramps fit, or the ramps are shrunk.
        n_stg[1]         = r_stg[0];
        n_stg[1].long_mv = (r_stg[0].n >= {16'b0, w_total});
        n_stg[1].run     = r_stg[0].n - {16'b0, w_total};
        // Multiply stage. On a short move the dividend na * n stays below total * 2^16.
        n_stg[2]     = r_stg[1];
        n_stg[2].rem = w_prod[31:16];
        n_stg[2].quo = w_prod[15:0];
        for (int k = 0; k < tmplan_pkg::DivStg; k++) begin
            v_div = r_stg[2+k];
            for (int b = 0; b < tmplan_pkg::BitsPerStg; b++) begin
                v_div = tmplan_pkg::div_step(v_div, w_total);
            end
            n_stg[3+k] = v_div;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NS-2:0], w_accept};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < NS; k++) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    // Final stage: pick full or shrunk ramps and clear everything on no motion or error.
    tmplan_pkg::t_item w_fin;
    logic [15:0]       n_acc;
    logic [31:0]       n_run;
    logic [15:0]       n_dec;

    assign w_fin = r_stg[NS-1];

    always_comb begin
        n_acc = w_fin.long_mv ? r_na : w_fin.quo;
        n_run = w_fin.long_mv ? w_fin.run : '0;
        n_dec = w_fin.long_mv ? r_nd : (w_fin.n[15:0] - w_fin.quo);
        if (w_fin.zero || w_fin.err) begin
            n_acc = '0;
            n_run = '0;
            n_dec = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_en) begin
            o_out_valid <= r_vld[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_direction    <= w_fin.neg;
            o_accel_steps  <= n_acc;
            o_run_steps    <= n_run;
            o_decel_steps  <= n_dec;
            o_phase_mask   <= {n_dec != '0, n_run != '0, n_acc != '0};
            o_no_motion    <= w_fin.zero;
            o_divide_error <= w_fin.err;
        end
    end

    // While the ramps are being recomputed no move may enter.
    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != tmplan_pkg::ST_IDLE) |-> o_in_stall)
        else $error("move accepted while ramp lengths are being recomputed");

    // A configuration write always restarts the ramp computation.
    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_state == tmplan_pkg::ST_LOAD))
        else $error("configuration write did not restart the ramp computation");

    // A real move always has at least one nonzero phase.
    a_move_has_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_no_motion && !o_divide_error) |-> (o_phase_mask != 3'b000))
        else $error("move planned with no phase");

    // A run phase only exists when both ramps are used at full length.
    a_run_full_ramps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_phase_mask[1]) |-> ((o_accel_steps == r_na) && (o_decel_steps == r_nd)))
        else $error("run phase planned with shrunk ramps");

endmodule

`default_nettype wire
